/* rtl/core/aip_pkg.sv */
package aip_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned BaseW  = 6;
    localparam int unsigned ValueW = 64;
    localparam int unsigned DigitW = 8;

    // characters the parser reacts to
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;
    localparam logic [ByteW-1:0] ChMinus = 8'h2D;
    localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChXLow  = 8'h78;
    localparam logic [ByteW-1:0] ChXUp   = 8'h58;
    localparam logic [ByteW-1:0] ChOLow  = 8'h6F;
    localparam logic [ByteW-1:0] ChOUp   = 8'h4F;
    localparam logic [ByteW-1:0] ChBLow  = 8'h62;
    localparam logic [ByteW-1:0] ChBUp   = 8'h42;

    localparam logic [BaseW-1:0] BaseAuto = 6'd0;
    localparam logic [BaseW-1:0] BaseBin  = 6'd2;
    localparam logic [BaseW-1:0] BaseOct  = 6'd8;
    localparam logic [BaseW-1:0] BaseDec  = 6'd10;
    localparam logic [BaseW-1:0] BaseHex  = 6'd16;

    localparam logic [DigitW-1:0] DigitNone = 8'hFF;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_PREFIX = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_TRAIL  = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [BaseW-1:0]    base;
        logic                neg;
        logic                seen;
        logic [ValueW-1:0]   acc;
    } parse_state_t;

    typedef struct packed {
        logic                ok;
        logic [ValueW-1:0]   value;
    } parse_result_t;

    // parser at rest: leading-whitespace phase, auto base, nothing gathered
    localparam parse_state_t StateIdle = '{
        phase: PH_LEAD,
        base:  BaseAuto,
        neg:   1'b0,
        seen:  1'b0,
        acc:   '0
    };

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == ChSpace) || (c == ChTab);
    endfunction

    // 0-9, a-z, A-Z map to 0..35; anything else is not a digit
    function automatic logic [DigitW-1:0] digit_value(input logic [ByteW-1:0] c);
        logic [DigitW-1:0] d;
        d = DigitNone;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = c - 8'h37;
        end
        return d;
    endfunction

endpackage

/* rtl/core/aip_step.sv */
// One character through the parse phases; next state and result.
module aip_step
(
    input  aip_pkg::parse_state_t          cur,
    input  logic [aip_pkg::ByteW-1:0]      text_byte,
    input  logic                           first_byte,
    input  logic                           last_byte,
    input  logic [aip_pkg::BaseW-1:0]      number_base,
    output aip_pkg::parse_state_t          nxt,
    output aip_pkg::parse_result_t         res
);

    aip_pkg::parse_state_t       st;
    aip_pkg::parse_state_t       clr;
    logic                        stop;
    logic [aip_pkg::DigitW-1:0]  dig;
    logic [aip_pkg::ValueW-1:0]  mac;

    assign dig = aip_pkg::digit_value(text_byte);

    always_comb
    begin
        clr       = '0;
        clr.phase = aip_pkg::PH_LEAD;

        st = cur;
        if (first_byte)
        begin
            st      = clr;
            st.base = number_base;
        end

        stop = 1'b0;
        mac  = '0;

        if (st.phase == aip_pkg::PH_LEAD)
        begin
            if (aip_pkg::is_blank(text_byte))
            begin
                stop = 1'b1;
            end
            else if (text_byte == aip_pkg::ChMinus)
            begin
                st.neg   = 1'b1;
                st.phase = aip_pkg::PH_SIGN;
                stop     = 1'b1;
            end
            else if (text_byte == aip_pkg::ChPlus)
            begin
                st.phase = aip_pkg::PH_SIGN;
                stop     = 1'b1;
            end
            else
            begin
                st.phase = aip_pkg::PH_SIGN;
            end
        end

        if (!stop)
        begin
            if (st.phase == aip_pkg::PH_SIGN)
            begin
                // auto mode: a leading zero may open a prefix, hold it a beat
                if (st.base == aip_pkg::BaseAuto && text_byte == aip_pkg::ChZero
                    && !last_byte)
                begin
                    st.phase = aip_pkg::PH_PREFIX;
                    stop     = 1'b1;
                end
                else
                begin
                    if (st.base == aip_pkg::BaseAuto)
                    begin
                        st.base = aip_pkg::BaseDec;
                    end
                    st.phase = aip_pkg::PH_DIGITS;
                end
            end
            else if (st.phase == aip_pkg::PH_PREFIX)
            begin
                stop     = 1'b1;
                st.phase = aip_pkg::PH_DIGITS;
                if (text_byte == aip_pkg::ChXLow || text_byte == aip_pkg::ChXUp)
                begin
                    st.base = aip_pkg::BaseHex;
                end
                else if (text_byte == aip_pkg::ChOLow || text_byte == aip_pkg::ChOUp)
                begin
                    st.base = aip_pkg::BaseOct;
                end
                else if (text_byte == aip_pkg::ChBLow || text_byte == aip_pkg::ChBUp)
                begin
                    st.base = aip_pkg::BaseBin;
                end
                else
                begin
                    // held zero was a decimal digit
                    stop    = 1'b0;
                    st.base = aip_pkg::BaseDec;
                    st.seen = 1'b1;
                    st.acc  = '0;
                end
            end
        end

        if (!stop && st.phase == aip_pkg::PH_DIGITS)
        begin
            if (dig < {2'b00, st.base})
            begin
                mac     = st.acc * {{(aip_pkg::ValueW-aip_pkg::BaseW){1'b0}}, st.base};
                st.acc  = mac + {{(aip_pkg::ValueW-aip_pkg::DigitW){1'b0}}, dig};
                st.seen = 1'b1;
                stop    = 1'b1;
            end
            else
            begin
                st.phase = aip_pkg::PH_TRAIL;
            end
        end

        if (!stop && st.phase == aip_pkg::PH_TRAIL)
        begin
            if (!aip_pkg::is_blank(text_byte))
            begin
                st.phase = aip_pkg::PH_ERROR;
            end
        end

        res.ok    = st.seen && (st.phase != aip_pkg::PH_ERROR);
        res.value = '0;
        if (res.ok)
        begin
            res.value = st.neg ? (~st.acc + 64'd1) : st.acc;
        end

        nxt = last_byte ? clr : st;
    end

endmodule

/* rtl/core/ascii_integer_parser.sv */
// Path of a string's last byte: input register, parse step, result register.
// Throughput: one byte per cycle, back to back, unless a last byte waits on a
// full, stalled result register; bounded by the accumulator multiply-add loop
// (64 x 6 multiply, add digit). Reset (rst_n low, asynchronous): input and result
// registers empty; parser in leading-whitespace phase, auto base, zero accumulator.
module ascii_integer_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] text_byte, [13:8] number_base, [15:14] zero
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] parsed_value
    output logic        m_axis_tuser    // [0] parse_ok
);

    // input register: one beat waiting for the parse step
    logic                          in_valid_reg;
    logic [aip_pkg::ByteW-1:0]     in_byte_reg;
    logic [aip_pkg::BaseW-1:0]     in_base_reg;
    logic                          in_first_reg;
    logic                          in_last_reg;

    // running parse state
    aip_pkg::parse_state_t         state_reg;
    aip_pkg::parse_state_t         state_next;
    aip_pkg::parse_result_t        step_res;

    // result register
    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [aip_pkg::ValueW-1:0]    out_value_reg;

    logic                          advance;

    // a buffered beat moves on unless it carries a result and the result
    // register is still full and stalled
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_base_reg  <= s_axis_tdata[13:8];
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    aip_step u_step
    (
        .cur         (state_reg),
        .text_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .last_byte   (in_last_reg),
        .number_base (in_base_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aip_pkg::StateIdle;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_ok_reg    <= step_res.ok;
            out_value_reg <= step_res.value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_ok_reg;

`ifndef SYNTHESIS
    // a failed parse always reports zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("failed parse with non-zero value");

    // a finished string leaves the parser in its reset state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg.phase == aip_pkg::PH_LEAD
            && state_reg.acc == 64'd0 && !state_reg.seen && !state_reg.neg
            && state_reg.base == aip_pkg::BaseAuto)
        else $error("parse state not cleared after last byte");

    // a result only appears for a last byte that moved through the step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result without a last byte");

    // a buffered byte is never dropped while it waits
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("buffered byte lost");
`endif

endmodule
